// File: hdl/mdet_pkg.sv
// Shared types and constants of the frame difference motion detector.
// Used by mdet_alu, mdet_seq, frame_difference_motion_detector and its testbench; no dependencies.

package mdet_pkg;

   // Frame store geometry.
   localparam int MAX_FRAME_PIXELS = 65536;
   localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);
   // Remainder of the mean division is below the frame size, which is at most the store depth.
   localparam int REM_W            = ADDR_W + 1;

   // Datapath widths fixed by the register and field definitions.
   localparam int PIXEL_W     = 8;
   localparam int SQUARE_W    = 2 * PIXEL_W;
   localparam int SUM_W       = 32;
   localparam int THRESHOLD_W = 16;
   localparam int QUIET_W     = 8;
   localparam int FRAME_W     = 17;
   localparam int MEAN_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = FRAME_W;

   // The division produces one quotient bit per step.
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_MOTION_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_QUIET_LIMIT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXELS_PER_FRAME = 2'd2;

   // Reset values of the registers.
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd50;
   localparam logic [QUIET_W-1:0]     QUIET_RESET     = 8'd5;
   localparam logic [FRAME_W-1:0]     FRAME_RESET     = 17'd65536;

   // Result codes.
   localparam logic RESULT_MOTION  = 1'b0;
   localparam logic RESULT_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_COMPARE,
      ST_OUTPUT
   } seq_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [1:0] {
      SRC_ACCUM,
      SRC_DIVIDE,
      SRC_COMPARE
   } alu_src_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic        accept_en;
      logic        square_en;
      logic        accum_en;
      logic        divide_en;
      logic        compare_en;
      logic        output_en;
      alu_op_type  alu_op;
      alu_src_type alu_src;
   } seq_ctrl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic req_valid;
      logic last_pixel;
      logic store_primed;
      logic div_done;
      logic motion;
      logic timeout_hit;
      logic rsp_free;
   } seq_status_type;

endpackage

// File: hdl/mdet_alu.sv
// Shared 32-bit add/subtract unit of the motion detector.
// Depends on mdet_pkg; serves accumulation, division steps and the threshold compare.

module mdet_alu (
   input  mdet_pkg::alu_op_type        op,
   input  logic [mdet_pkg::SUM_W-1:0]  a,
   input  logic [mdet_pkg::SUM_W-1:0]  b,
   output logic [mdet_pkg::SUM_W-1:0]  result,
   output logic                        carry
);

   // For a subtraction the carry output is the borrow.
   always_comb begin
      unique case (op)
         mdet_pkg::ALU_ADD: {carry, result} = {1'b0, a} + {1'b0, b};
         mdet_pkg::ALU_SUB: {carry, result} = {1'b0, a} - {1'b0, b};
         default:           {carry, result} = {1'b0, a} + {1'b0, b};
      endcase
   end

endmodule

// File: hdl/mdet_seq.sv
// Sequencer of the motion detector: steps one pixel through square, accumulate and,
// at frame end, the iterative division and compare. Depends on mdet_pkg.

module mdet_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  mdet_pkg::seq_status_type status,
   output mdet_pkg::seq_ctrl_type   ctrl
);

   mdet_pkg::seq_state_type state_ff;
   mdet_pkg::seq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdet_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdet_pkg::ST_IDLE: begin
            if (status.req_valid) state_in = mdet_pkg::ST_SQUARE;
         end
         mdet_pkg::ST_SQUARE: begin
            state_in = mdet_pkg::ST_ACCUM;
         end
         mdet_pkg::ST_ACCUM: begin
            if (status.last_pixel && status.store_primed) state_in = mdet_pkg::ST_DIVIDE;
            else state_in = mdet_pkg::ST_IDLE;
         end
         mdet_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = mdet_pkg::ST_COMPARE;
         end
         mdet_pkg::ST_COMPARE: begin
            if (status.motion || status.timeout_hit) state_in = mdet_pkg::ST_OUTPUT;
            else state_in = mdet_pkg::ST_IDLE;
         end
         mdet_pkg::ST_OUTPUT: begin
            if (status.rsp_free) state_in = mdet_pkg::ST_IDLE;
         end
         default: state_in = mdet_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.alu_op     = mdet_pkg::ALU_ADD;
      ctrl.alu_src    = mdet_pkg::SRC_ACCUM;
      unique case (state_ff)
         mdet_pkg::ST_IDLE:    ctrl.accept_en = 1'b1;
         mdet_pkg::ST_SQUARE:  ctrl.square_en = 1'b1;
         mdet_pkg::ST_ACCUM: begin
            ctrl.accum_en = 1'b1;
            ctrl.alu_op   = mdet_pkg::ALU_ADD;
            ctrl.alu_src  = mdet_pkg::SRC_ACCUM;
         end
         mdet_pkg::ST_DIVIDE: begin
            ctrl.divide_en = 1'b1;
            ctrl.alu_op    = mdet_pkg::ALU_SUB;
            ctrl.alu_src   = mdet_pkg::SRC_DIVIDE;
         end
         mdet_pkg::ST_COMPARE: begin
            ctrl.compare_en = 1'b1;
            ctrl.alu_op     = mdet_pkg::ALU_SUB;
            ctrl.alu_src    = mdet_pkg::SRC_COMPARE;
         end
         mdet_pkg::ST_OUTPUT:  ctrl.output_en = 1'b1;
         default:              ctrl.accept_en = 1'b0;
      endcase
   end

endmodule

// File: hdl/frame_difference_motion_detector.sv
// Top level of the frame difference motion detector: frame store, datapath registers,
// configuration registers and result register. Depends on mdet_pkg, mdet_alu, mdet_seq.
//
// Usage: 8-bit grayscale pixels enter in raster order on the req_ channel; a transaction
// completes at a rising edge with req_valid high and req_stall low. The first frame after
// reset, or after any result, only fills the frame store. Each later frame accumulates the
// squared pixel differences against the store and overwrites it. At frame end the mean
// (sum divided by the frame size) above the motion threshold gives a motion result;
// otherwise a quiet frame counter runs and a timeout result is given at the quiet limit.
// Results leave on the rsp_ channel, one transaction per result.
// Pixel flow: each pixel passes accept, square and accumulate before the next one is taken,
// set by the one-pixel sequencer and the single store port. At a compared frame end the
// shared adder runs 32 restoring division steps and one compare; req_stall stays high
// until the result is in the output register, or until the compare when it gives none.
// The result sits in an output register; if rsp_stall holds it, the block keeps taking
// pixels, and only a further result waits until the register is free.
// Reset (synchronous, active high) clears the sequencer, counters, configuration registers
// and rsp_valid, not the payload registers or frame store; the first frame primes the store.
// Configuration transactions on csr_ are always taken and belong between frames or pixels.

module frame_difference_motion_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mdet_pkg::PIXEL_W-1:0]        req_gray_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [mdet_pkg::MEAN_W-1:0]         rsp_mean_difference,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mdet_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mdet_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SUM_W  = mdet_pkg::SUM_W;
   localparam int ADDR_W = mdet_pkg::ADDR_W;
   localparam int REM_W  = mdet_pkg::REM_W;

   mdet_pkg::seq_ctrl_type   ctrl;
   mdet_pkg::seq_status_type status;

   // Configuration registers.
   logic [mdet_pkg::THRESHOLD_W-1:0] threshold_ff;
   logic [mdet_pkg::QUIET_W-1:0]     quiet_limit_ff;
   logic [mdet_pkg::FRAME_W-1:0]     frame_pixels_ff;

   // Frame store, read on pixel accept and written in the accumulate step.
   logic [mdet_pkg::PIXEL_W-1:0] store_mem [mdet_pkg::MAX_FRAME_PIXELS];
   logic [mdet_pkg::PIXEL_W-1:0] old_pixel_ff;

   logic [mdet_pkg::PIXEL_W-1:0]  pixel_ff;
   logic [mdet_pkg::SQUARE_W-1:0] square_ff;
   logic [mdet_pkg::SQUARE_W-1:0] square_in;
   logic [mdet_pkg::PIXEL_W-1:0]  abs_diff;

   logic [SUM_W-1:0]             sum_ff;
   logic [ADDR_W-1:0]            position_ff;
   logic                         primed_ff;
   logic [mdet_pkg::QUIET_W-1:0] compared_ff;

   logic [REM_W-1:0]               rem_ff;
   logic [SUM_W-1:0]               quo_ff;
   logic [mdet_pkg::DIV_CNT_W-1:0] step_ff;
   logic                           kind_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic [mdet_pkg::MEAN_W-1:0] rsp_mean_ff;

   logic [SUM_W-1:0]             frame_size;
   logic                         last_pixel;
   logic [REM_W:0]               rem_shift;
   logic [SUM_W-1:0]             alu_a;
   logic [SUM_W-1:0]             alu_b;
   logic [SUM_W-1:0]             alu_result;
   logic                         alu_carry;
   logic [SUM_W-1:0]             sum_sat;
   logic [mdet_pkg::QUIET_W-1:0] compared_inc;
   logic [mdet_pkg::QUIET_W-1:0] quiet_limit;
   logic                         timeout_hit;
   logic                         req_accept;
   logic                         rsp_free;

   assign req_stall  = !ctrl.accept_en;
   assign req_accept = req_valid && ctrl.accept_en;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Effective frame size: zero acts as one, anything above the store depth as the depth.
   always_comb begin
      frame_size = SUM_W'(frame_pixels_ff);
      if (frame_size == '0) frame_size = SUM_W'(1);
      if (frame_size > SUM_W'(mdet_pkg::MAX_FRAME_PIXELS)) begin
         frame_size = SUM_W'(mdet_pkg::MAX_FRAME_PIXELS);
      end
   end

   assign last_pixel = (SUM_W'(position_ff) + SUM_W'(1)) >= frame_size;

   // Absolute difference and its square for the current pixel.
   assign abs_diff  = (pixel_ff > old_pixel_ff) ? pixel_ff - old_pixel_ff
                                                : old_pixel_ff - pixel_ff;
   assign square_in = mdet_pkg::SQUARE_W'(abs_diff) * mdet_pkg::SQUARE_W'(abs_diff);

   // Operand selection for the shared adder.
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      unique case (ctrl.alu_src)
         mdet_pkg::SRC_ACCUM: begin
            alu_a = sum_ff;
            alu_b = SUM_W'(square_ff);
         end
         mdet_pkg::SRC_DIVIDE: begin
            alu_a = SUM_W'(rem_shift);
            alu_b = frame_size;
         end
         mdet_pkg::SRC_COMPARE: begin
            // A borrow here means the mean is above the threshold.
            alu_a = SUM_W'(threshold_ff);
            alu_b = quo_ff;
         end
         default: begin
            alu_a = sum_ff;
            alu_b = SUM_W'(square_ff);
         end
      endcase
   end

   mdet_alu u_alu (
      .op     (ctrl.alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .carry  (alu_carry)
   );

   // The running sum saturates instead of wrapping.
   assign sum_sat = alu_carry ? '1 : alu_result;

   assign compared_inc = compared_ff + mdet_pkg::QUIET_W'(1);
   assign quiet_limit  = (quiet_limit_ff == '0) ? mdet_pkg::QUIET_W'(1) : quiet_limit_ff;
   assign timeout_hit  = compared_inc >= quiet_limit;

   always_comb begin
      status.req_valid    = req_valid;
      status.last_pixel   = last_pixel;
      status.store_primed = primed_ff;
      status.div_done     = step_ff == mdet_pkg::DIV_CNT_W'(mdet_pkg::DIV_STEPS - 1);
      status.motion       = alu_carry;
      status.timeout_hit  = timeout_hit;
      status.rsp_free     = rsp_free;
   end

   mdet_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Configuration writes; an index past the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= mdet_pkg::THRESHOLD_RESET;
         quiet_limit_ff  <= mdet_pkg::QUIET_RESET;
         frame_pixels_ff <= mdet_pkg::FRAME_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mdet_pkg::REG_MOTION_THRESHOLD:
               threshold_ff <= csr_wdata[mdet_pkg::THRESHOLD_W-1:0];
            mdet_pkg::REG_QUIET_LIMIT:
               quiet_limit_ff <= csr_wdata[mdet_pkg::QUIET_W-1:0];
            mdet_pkg::REG_PIXELS_PER_FRAME:
               frame_pixels_ff <= csr_wdata[mdet_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame store ports.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         old_pixel_ff <= store_mem[position_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accum_en) begin
         store_mem[position_ff] <= pixel_ff;
      end
   end

   // Payload registers of one pixel and of the division.
   always_ff @(posedge clock) begin
      if (req_accept) pixel_ff <= req_gray_pixel;
      if (ctrl.square_en) square_ff <= square_in;
      if (ctrl.accum_en && last_pixel) begin
         rem_ff  <= '0;
         quo_ff  <= sum_sat;
      end else if (ctrl.divide_en) begin
         // Restoring division: keep the trial difference when it did not borrow.
         rem_ff <= alu_carry ? rem_shift[REM_W-1:0] : alu_result[REM_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], !alu_carry};
      end
      if (ctrl.compare_en) begin
         kind_ff <= alu_carry ? mdet_pkg::RESULT_MOTION : mdet_pkg::RESULT_TIMEOUT;
      end
   end

   // Control state: position, sum, priming, quiet count and division step.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         sum_ff      <= '0;
         primed_ff   <= 1'b0;
         compared_ff <= '0;
         step_ff     <= '0;
      end else begin
         if (ctrl.accum_en) begin
            if (!last_pixel) begin
               position_ff <= position_ff + ADDR_W'(1);
               if (primed_ff) sum_ff <= sum_sat;
            end else begin
               // Frame end: the sum is either dropped (priming) or handed to the divider.
               position_ff <= '0;
               sum_ff      <= '0;
               primed_ff   <= 1'b1;
               step_ff     <= '0;
            end
         end
         if (ctrl.divide_en) step_ff <= step_ff + mdet_pkg::DIV_CNT_W'(1);
         if (ctrl.compare_en && !alu_carry) compared_ff <= compared_inc;
         if (ctrl.output_en && rsp_free) begin
            primed_ff   <= 1'b0;
            compared_ff <= '0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.output_en && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.output_en && rsp_free) begin
         rsp_kind_ff <= kind_ff;
         rsp_mean_ff <= quo_ff[mdet_pkg::MEAN_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_mean_difference = rsp_mean_ff;

endmodule

// File: verif/frame_difference_motion_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of frame_difference_motion_detector: a pixel driver, a result monitor
// and a frame-level predictor of the detector. Depends on mdet_pkg and the detector RTL only.

module frame_difference_motion_detector_tb;

   localparam int PIXEL_W          = mdet_pkg::PIXEL_W;
   localparam int MEAN_W           = mdet_pkg::MEAN_W;
   localparam int THRESHOLD_W      = mdet_pkg::THRESHOLD_W;
   localparam int QUIET_W          = mdet_pkg::QUIET_W;
   localparam int FRAME_W          = mdet_pkg::FRAME_W;
   localparam int CSR_INDEX_W      = mdet_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W       = mdet_pkg::CSR_DATA_W;
   localparam int ADDR_W           = mdet_pkg::ADDR_W;
   localparam int MAX_FRAME_PIXELS = mdet_pkg::MAX_FRAME_PIXELS;

   localparam int RESET_CYCLES   = 11;
   // Covers the frame-end division and compare of a compared frame plus any pixel in flight,
   // so this is comfortably more than the block can be busy.
   localparam int SETTLE_CYCLES  = 120;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PIXEL_TARGET   = 1725;
   localparam int PATTERN_DEPTH  = 512;
   localparam int PATTERN_W      = $clog2(PATTERN_DEPTH);
   localparam int REPORT_LINES   = 40;
   // The index field has room for a fourth register that does not exist.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [MEAN_W-1:0] mean;
   } detection_type;

   // Every input of the block has a known value from time zero.
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_gray_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_result_kind;
   logic [MEAN_W-1:0]      rsp_mean_difference;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   // Shadow of the configuration registers, updated on every csr transaction to an existing register.
   logic [THRESHOLD_W-1:0] shadow_threshold = mdet_pkg::THRESHOLD_RESET;
   logic [QUIET_W-1:0]     shadow_quiet     = mdet_pkg::QUIET_RESET;
   logic [FRAME_W-1:0]     shadow_frame     = mdet_pkg::FRAME_RESET;

   // Predictor state. Entries of the frame store below written_extent have been written; the
   // stimulus never lets a compared frame read beyond that point.
   logic [PIXEL_W-1:0] stored_frame [MAX_FRAME_PIXELS];
   int unsigned        next_position  = 0;
   int unsigned        squared_sum    = 0;
   int unsigned        quiet_frames   = 0;
   int unsigned        written_extent = 0;
   bit                 model_primed   = 1'b0;

   detection_type      due_detections [$];
   logic [PIXEL_W-1:0] pixel_queue [$];

   int unsigned pixels_queued   = 0;
   int unsigned mismatch_count  = 0;

   // Idling control. When steady is set, neither side inserts random gaps. hold_ask is bumped
   // by the stimulus to ask the receiver for one long hold-off.
   logic        steady       = 1'b0;
   int unsigned hold_ask     = 0;
   int unsigned holds_served = 0;
   int unsigned send_gap     = 0;
   int unsigned stall_left   = 0;
   int unsigned hold_left    = 0;
   int unsigned idle_cycles  = 0;

   frame_difference_motion_detector i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_gray_pixel      (req_gray_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_mean_difference (rsp_mean_difference),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // A frame size of zero behaves as one pixel, and sizes beyond the store are clipped to it.
   function automatic int unsigned effective_frame_size(input logic [FRAME_W-1:0] value);
      if (value == '0)
         return 1;
      if (32'(value) > MAX_FRAME_PIXELS)
         return MAX_FRAME_PIXELS;
      return 32'(value);
   endfunction

   // Gap length for either side: none when steady, else mostly none, sometimes short, rarely long.
   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES)
         $display("[%0t] detector check failed: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Steps the frame-level model by one accepted pixel. A detection is queued only on the last
   // pixel of a compared frame, when the mean is above the threshold or the quiet count runs out.
   task automatic advance_frame_model(input logic [PIXEL_W-1:0] pixel);
      int unsigned   frame_len;
      int unsigned   pos;
      int unsigned   old_value;
      int unsigned   delta;
      int unsigned   square;
      int unsigned   mean;
      int unsigned   limit;
      detection_type found;
      frame_len = effective_frame_size(shadow_frame);
      pos = next_position;
      if (pos >= MAX_FRAME_PIXELS)
         pos = MAX_FRAME_PIXELS - 1;
      if (model_primed) begin
         old_value = 32'(stored_frame[pos[ADDR_W-1:0]]);
         delta = (32'(pixel) > old_value) ? 32'(pixel) - old_value : old_value - 32'(pixel);
         square = delta * delta;
         if (squared_sum > 32'hFFFF_FFFF - square)
            squared_sum = 32'hFFFF_FFFF;
         else
            squared_sum = squared_sum + square;
      end
      stored_frame[pos[ADDR_W-1:0]] = pixel;
      if (pos + 1 > written_extent)
         written_extent = pos + 1;
      // A shrunken frame size ends the frame at the first pixel at or past the new end.
      if (pos + 1 < frame_len) begin
         next_position = pos + 1;
         return;
      end
      next_position = 0;
      if (!model_primed) begin
         model_primed = 1'b1;
         squared_sum = 0;
         return;
      end
      mean = squared_sum / frame_len;
      squared_sum = 0;
      found.mean = mean[MEAN_W-1:0];
      if (mean > 32'(shadow_threshold)) begin
         found.kind = mdet_pkg::RESULT_MOTION;
         due_detections.push_back(found);
         model_primed = 1'b0;
         quiet_frames = 0;
         return;
      end
      // A quiet limit of zero acts as one, and a lowered limit fires as soon as it is reached.
      limit = (shadow_quiet == '0) ? 1 : 32'(shadow_quiet);
      quiet_frames = (quiet_frames + 1) & 32'hFF;
      if (quiet_frames >= limit) begin
         found.kind = mdet_pkg::RESULT_TIMEOUT;
         due_detections.push_back(found);
         model_primed = 1'b0;
         quiet_frames = 0;
      end
   endtask

   // Pixel driver: presents the next queued pixel once the previous transaction has completed
   // and any chosen gap has run out. A stalled pixel is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pixel_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_gray_pixel <= pixel_queue.pop_front();
            send_gap <= idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request so that the output
   // register stays full and the block has to stall its pixel input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_ask) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= idle_len();
      end
   end

   // Monitor: feeds accepted pixels and register writes to the predictor and checks every
   // accepted result against the oldest detection that is due.
   always @(posedge clock) begin : monitor
      detection_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mdet_pkg::REG_MOTION_THRESHOLD:
                  shadow_threshold = csr_wdata[THRESHOLD_W-1:0];
               mdet_pkg::REG_QUIET_LIMIT:
                  shadow_quiet = csr_wdata[QUIET_W-1:0];
               mdet_pkg::REG_PIXELS_PER_FRAME:
                  shadow_frame = csr_wdata[FRAME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            advance_frame_model(req_gray_pixel);
         if (rsp_valid && !rsp_stall) begin
            if (due_detections.size() == 0) begin
               report_mismatch($sformatf("result kind %0d mean %0d arrived with none due",
                                         rsp_result_kind, rsp_mean_difference));
            end else begin
               want = due_detections.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch($sformatf("result kind %0d, predicted %0d",
                                            rsp_result_kind, want.kind));
               if (rsp_mean_difference !== want.mean)
                  report_mismatch($sformatf("mean difference %0d, predicted %0d",
                                            rsp_mean_difference, want.mean));
            end
         end
      end
   end

   // Watchdog: a long run of cycles without any transaction on any channel means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_pixel(input logic [PIXEL_W-1:0] pixel);
      pixel_queue.push_back(pixel);
      pixels_queued++;
   endtask

   // Waits until every queued pixel has been taken and every due detection has arrived, then
   // lets the block finish any frame-end division that produces no result.
   task automatic wait_quiescent();
      while (pixel_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (due_detections.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. The trailing edge lets the shadow copy settle before it is read, and
   // keeps csr_valid low for a cycle between back-to-back writes.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      unique case (roll)
         0:          return CSR_DATA_W'(0);
         1:          return CSR_DATA_W'(65025);
         2:          return CSR_DATA_W'(50);
         3, 4, 5, 6: return CSR_DATA_W'($urandom_range(0, 400));
         7, 8:       return CSR_DATA_W'($urandom_range(401, 20000));
         default:    return CSR_DATA_W'($urandom_range(0, 65025));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_quiet();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      unique case (roll)
         0:       return CSR_DATA_W'(0);
         1:       return CSR_DATA_W'(255);
         2, 3, 4: return CSR_DATA_W'(1);
         5, 6, 7: return CSR_DATA_W'($urandom_range(2, 4));
         default: return CSR_DATA_W'($urandom_range(5, 12));
      endcase
   endfunction

   // Frame sizes stay small so that many frames fit in the run. Once the store is primed the
   // size may not grow past what has been written, or a compared frame would read unwritten
   // store entries.
   function automatic logic [CSR_DATA_W-1:0] pick_frame_size();
      int unsigned roll;
      logic [CSR_DATA_W-1:0] value;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         value = '0;
      else if (roll < 3)
         value = CSR_DATA_W'(1);
      else if (roll < 10)
         value = CSR_DATA_W'($urandom_range(2, 8));
      else if (roll < 18)
         value = CSR_DATA_W'($urandom_range(9, 40));
      else
         value = CSR_DATA_W'($urandom_range(41, 160));
      if (model_primed && effective_frame_size(value) > written_extent)
         value = CSR_DATA_W'($urandom_range(1, written_extent));
      return value;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_oversize();
      int unsigned roll;
      roll = $urandom_range(0, 2);
      if (roll == 0)
         return CSR_DATA_W'(MAX_FRAME_PIXELS);
      if (roll == 1)
         return 17'h1FFFF;
      return CSR_DATA_W'($urandom_range(MAX_FRAME_PIXELS + 1, 17'h1FFFE));
   endfunction

   // Queues whole frames built around one random picture: exact repeats and lightly noisy
   // copies keep the mean low, fully random and inverted frames push it high.
   task automatic queue_frames(input int unsigned frame_len, input int unsigned frames);
      logic [PIXEL_W-1:0] picture [PATTERN_DEPTH];
      int unsigned style;
      int unsigned spread;
      int level;
      for (int i = 0; i < frame_len; i++)
         picture[i[PATTERN_W-1:0]] = PIXEL_W'($urandom_range(0, 255));
      for (int f = 0; f < frames; f++) begin
         style = $urandom_range(0, 9);
         spread = $urandom_range(1, 6);
         for (int i = 0; i < frame_len; i++) begin
            if (style < 4) begin
               level = int'(picture[i[PATTERN_W-1:0]]);
            end else if (style < 7) begin
               level = int'(picture[i[PATTERN_W-1:0]]) + int'($urandom_range(0, 2 * spread))
                       - int'(spread);
               if (level < 0)
                  level = 0;
               if (level > 255)
                  level = 255;
            end else if (style < 9) begin
               level = int'($urandom_range(0, 255));
            end else begin
               level = 255 - int'(picture[i[PATTERN_W-1:0]]);
            end
            queue_pixel(level[PIXEL_W-1:0]);
         end
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned frame_len;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The reset values are in force first: a 65536-pixel frame starts priming,
      // and shrinking the size mid-frame ends it at the next pixel.
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      queue_pixel(8'd128);
      queue_pixel(8'd1);
      wait_quiescent();
      write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, CSR_DATA_W'(3));
      // Closes the priming frame, then a frame with full-scale differences gives the largest
      // in-range mean as a motion result under the default threshold.
      queue_pixel(8'd7);
      queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      wait_quiescent();

      // Quiet limit zero acts as one, frame size zero acts as one, threshold at its maximum.
      write_reg(mdet_pkg::REG_QUIET_LIMIT, CSR_DATA_W'(0));
      write_reg(mdet_pkg::REG_MOTION_THRESHOLD, CSR_DATA_W'(65025));
      write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, CSR_DATA_W'(0));
      queue_pixel(8'd7);
      queue_pixel(8'd200);
      wait_quiescent();

      // Threshold zero: an identical frame times out with mean zero, a one-step change is motion.
      write_reg(mdet_pkg::REG_MOTION_THRESHOLD, CSR_DATA_W'(0));
      queue_pixel(8'd5);
      queue_pixel(8'd5);
      queue_pixel(8'd5);
      queue_pixel(8'd6);
      wait_quiescent();

      // An oversize frame setting is clipped to the store depth; it is cut short mid-frame.
      write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, 17'h1FFFF);
      write_reg(REG_UNUSED, 17'h1FFFF);
      queue_pixel(8'd9);
      queue_pixel(8'd250);
      queue_pixel(8'd17);
      wait_quiescent();
      write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, CSR_DATA_W'(2));
      queue_pixel(8'd3);
      queue_pixel(8'd250);
      queue_pixel(8'd9);
      wait_quiescent();
      write_reg(mdet_pkg::REG_QUIET_LIMIT, CSR_DATA_W'(255));
      write_reg(mdet_pkg::REG_MOTION_THRESHOLD, CSR_DATA_W'(50));

      // Random part. Each phase begins with the block idle, may rewrite any register, and then
      // sends whole frames, sometimes followed by a broken partial frame.
      phase = 0;
      while (pixels_queued < PIXEL_TARGET) begin
         wait_quiescent();
         if (phase == 0) begin
            // Tiny frames with a result on every compared frame while the receiver holds off:
            // the output register fills and the block must stall its pixel input.
            steady = 1'b1;
            write_reg(mdet_pkg::REG_MOTION_THRESHOLD, CSR_DATA_W'(100));
            write_reg(mdet_pkg::REG_QUIET_LIMIT, CSR_DATA_W'(1));
            write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, CSR_DATA_W'(2));
            hold_ask++;
            queue_frames(2, 24);
         end else begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
               write_reg(mdet_pkg::REG_MOTION_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 1))
               write_reg(mdet_pkg::REG_QUIET_LIMIT, pick_quiet());
            if (!model_primed && $urandom_range(0, 9) == 0) begin
               // Start priming at a huge size, then shrink it before the frame gets long.
               write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, pick_oversize());
               repeat ($urandom_range(8, 30)) queue_pixel(PIXEL_W'($urandom_range(0, 255)));
               wait_quiescent();
               write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, pick_frame_size());
            end else if ($urandom_range(0, 1)) begin
               write_reg(mdet_pkg::REG_PIXELS_PER_FRAME, pick_frame_size());
            end
            frame_len = effective_frame_size(shadow_frame);
            queue_frames(frame_len, (frame_len > 40) ? $urandom_range(1, 2)
                                                     : $urandom_range(1, 8));
            if (frame_len > 1 && $urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, frame_len - 1))
                  queue_pixel(PIXEL_W'($urandom_range(0, 255)));
         end
         phase++;
      end

      wait_quiescent();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
